@@ design/ktcr_pkg.sv @@
// Shared types and constants for the k-ary tree child rank generator.
// Used by ktcr_ctrl, ktcr_dp and kary_tree_child_ranks_core; no dependencies.
package ktcr_pkg;

  // Field widths of the stream items and configuration registers.
  localparam int unsigned RANK_W  = 16;
  localparam int unsigned ARITY_W = 5;
  localparam int unsigned CHILD_W = 5;
  localparam int unsigned CFG_IDX_W = 2;

  // Level size register: one level below 2^16 times an arity below 32.
  localparam int unsigned LVL_W = 21;
  // Child rank accumulator: wide enough that base + c * stride never wraps.
  localparam int unsigned ACC_W = 28;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ARITY      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER_MODE = 2'd2;

  // Order modes.
  localparam logic ORDER_INTERLEAVED = 1'b0;
  localparam logic ORDER_HEAP        = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;          // capture a new sender and set up the first child
    logic search_step;   // remove one level size and scale it by k
    logic search_done;   // level found: set stride and first child
    logic emit;          // push the current child into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic reject;        // new sender has no children (k is zero or outside tree)
    logic direct;        // stride is one, no level search needed
    logic rem_ge_lvl;    // remaining rank still covers the current level
    logic r_ge_n;        // current child lies past the end of the tree
    logic last_child;    // current child is the final one kept
    logic out_free;      // output register can take a new item this cycle
  } status_t;

endpackage

@@ design/ktcr_ctrl.sv @@
// Controller state machine of the k-ary tree child rank generator.
// Depends on ktcr_pkg; drives commands into ktcr_dp and reads its status.
module ktcr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  ktcr_pkg::status_t status,
  output ktcr_pkg::cmd_t    cmd
);
  import ktcr_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = s_tvalid && s_tready;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && !status.reject) begin
          state_next = status.direct ? ST_EMIT : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (!status.rem_ge_lvl) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.r_ge_n) begin
          state_next = ST_IDLE;
        end else if (status.out_free && status.last_child) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs. No item is taken while reset is held.
  always_comb begin
    s_tready         = (state == ST_IDLE) && !rst;
    cmd.load         = accept;
    cmd.search_step  = (state == ST_SEARCH) && status.rem_ge_lvl;
    cmd.search_done  = (state == ST_SEARCH) && !status.rem_ge_lvl;
    cmd.emit         = (state == ST_EMIT) && !status.r_ge_n && status.out_free;
  end

endmodule

@@ design/ktcr_dp.sv @@
// Datapath of the k-ary tree child rank generator: level search, child
// accumulator and output register. Depends on ktcr_pkg; driven by ktcr_ctrl.
module ktcr_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  ktcr_pkg::cmd_t               cmd,
  output ktcr_pkg::status_t            status,
  input  logic [ktcr_pkg::RANK_W-1:0]  sender,
  input  logic [ktcr_pkg::ARITY_W-1:0] arity,
  input  logic [ktcr_pkg::RANK_W-1:0]  node_count,
  input  logic                         order_mode,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ktcr_pkg::RANK_W-1:0]  receiver,
  output logic [ktcr_pkg::CHILD_W-1:0] child_index,
  output logic                         last
);
  import ktcr_pkg::*;

  logic [RANK_W-1:0]  s_reg;
  logic [RANK_W-1:0]  n_reg;
  logic [ARITY_W-1:0] k_reg;
  logic [RANK_W-1:0]  rem;
  logic [LVL_W-1:0]   lvl;
  logic [LVL_W-1:0]   stride;
  logic [ACC_W-1:0]   r;
  logic [CHILD_W-1:0] c;

  logic [ACC_W-1:0]   r_step;
  logic [LVL_W-1:0]   heap_base;
  logic [LVL_W-1:0]   lvl_scaled;

  // Status for the controller.
  assign r_step     = r + ACC_W'(stride);
  assign heap_base  = LVL_W'(arity) * LVL_W'(sender);
  assign lvl_scaled = lvl * LVL_W'(k_reg);

  always_comb begin
    status.reject     = (arity == '0) || (sender >= node_count);
    status.direct     = (order_mode == ORDER_HEAP) || (arity == ARITY_W'(1));
    status.rem_ge_lvl = LVL_W'(rem) >= lvl;
    status.r_ge_n     = r >= ACC_W'(n_reg);
    status.last_child = (CHILD_W'(c) == CHILD_W'(k_reg)) || (r_step >= ACC_W'(n_reg));
    status.out_free   = !out_valid || out_ready;
  end

  // Sender, level search and child accumulator.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s_reg  <= sender;
      n_reg  <= node_count;
      k_reg  <= arity;
      rem    <= sender;
      lvl    <= LVL_W'(1);
      stride <= LVL_W'(1);
      c      <= CHILD_W'(1);
      if (order_mode == ORDER_HEAP) begin
        r <= ACC_W'(heap_base) + ACC_W'(1);
      end else begin
        r <= ACC_W'(sender) + ACC_W'(1);
      end
    end else if (cmd.search_step) begin
      rem <= rem - lvl[RANK_W-1:0];
      lvl <= lvl_scaled;
    end else if (cmd.search_done) begin
      stride <= lvl;
      r      <= ACC_W'(s_reg) + ACC_W'(lvl);
    end else if (cmd.emit) begin
      r <= r_step;
      c <= c + CHILD_W'(1);
    end
  end

  // Output register; holds one item until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      receiver    <= r[RANK_W-1:0];
      child_index <= c;
      last        <= status.last_child;
    end
  end

endmodule

@@ design/kary_tree_child_ranks_core.sv @@
// Each sender rank accepted on the slave stream produces, in child order, the
// ranks of its children in a k-ary broadcast tree over node_count nodes, the
// final one marked with tlast; a sender at or beyond node_count, or an arity
// of zero, produces nothing. In interleaved order (order_mode 0) the sender's
// level L is found by a search loop that removes one level size per cycle; an
// item is entered, the loop runs L search steps and a step to close the search,
// and then the children are emitted one after another (up to arity; none when no
// child fits), held back whenever the master side stalls; in heap order and for
// arity one there is no search. One item is worked on at a time; the next is
// taken as soon as the last child sits in the output register. Arity above
// MAX_ARITY is treated as MAX_ARITY, and ranks are reduced to RANK_BITS bits.
//
// Top level: configuration registers and stream ports. Depends on ktcr_pkg,
// ktcr_ctrl and ktcr_dp.
module kary_tree_child_ranks_core #(
  parameter int unsigned RANK_BITS = 16,
  parameter int unsigned MAX_ARITY = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration write port.
  input  logic                           cfg_we,
  input  logic [ktcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ktcr_pkg::RANK_W-1:0]    cfg_data,
  // Slave stream. tdata: sender [15:0].
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [15:0]                    s_tdata,
  // Master stream. tdata: receiver [15:0], child_index [20:16], zero [23:21].
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [23:0]                    m_tdata,
  output logic                           m_tlast
);
  import ktcr_pkg::*;

  localparam int unsigned SatArity = (MAX_ARITY > 31) ? 31 : MAX_ARITY;
  localparam logic [RANK_W-1:0] RankMask = (RANK_BITS >= RANK_W) ? {RANK_W{1'b1}} :
                                           RANK_W'((64'd1 << RANK_BITS) - 64'd1);

  logic [ARITY_W-1:0] arity;
  logic [RANK_W-1:0]  node_count;
  logic               order_mode;

  logic [ARITY_W-1:0] arity_sat;
  logic [RANK_W-1:0]  sender_masked;
  logic [RANK_W-1:0]  node_count_masked;
  logic [RANK_W-1:0]  receiver;
  logic [CHILD_W-1:0] child_index;

  cmd_t    cmd;
  status_t status;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      arity      <= ARITY_W'(2);
      node_count <= RANK_W'(16);
      order_mode <= ORDER_INTERLEAVED;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ARITY:      arity      <= cfg_data[ARITY_W-1:0];
        REG_NODE_COUNT: node_count <= cfg_data;
        REG_ORDER_MODE: order_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Arity saturation and rank width reduction.
  assign arity_sat = (arity > ARITY_W'(SatArity)) ? ARITY_W'(SatArity) : arity;
  assign sender_masked     = s_tdata & RankMask;
  assign node_count_masked = node_count & RankMask;

  ktcr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ktcr_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .sender      (sender_masked),
    .arity       (arity_sat),
    .node_count  (node_count_masked),
    .order_mode  (order_mode),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .receiver    (receiver),
    .child_index (child_index),
    .last        (m_tlast)
  );

  assign m_tdata = {3'b000, child_index, receiver};

endmodule

@@ test/kary_tree_child_ranks_core_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for kary_tree_child_ranks_core: sender ranks are streamed in and
// every emitted child rank is checked against a built-in predictor of the k-ary tree.
// Depends on ktcr_pkg and kary_tree_child_ranks_core only.
module kary_tree_child_ranks_core_test;
  import ktcr_pkg::*;

  localparam int unsigned MAX_ARITY   = 16;
  localparam int unsigned SETTLE_WAIT = 50;
  localparam int unsigned CYCLE_LIMIT = 300000;

  // One expected child of a sender.
  typedef struct packed {
    logic [RANK_W-1:0]  rank;
    logic [CHILD_W-1:0] index;
    logic               last;
  } child_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_ARITY;
  logic [RANK_W-1:0]    cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [15:0]          s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [23:0]          m_tdata;
  logic                 m_tlast;

  // Mirror of the configuration registers, as the block should hold them.
  logic [ARITY_W-1:0]   tree_arity = 5'd2;
  logic [RANK_W-1:0]    tree_nodes = 16'd16;
  logic                 tree_order = ORDER_INTERLEAVED;

  logic [15:0]          sender_q[$];
  child_t               child_q[$];
  int unsigned          senders_queued = 0;
  int unsigned          senders_taken = 0;
  int unsigned          mismatch_count = 0;
  int unsigned          cycle_count = 0;
  logic                 sender_taken = 1'b0;

  // Idle rates in percent, and the request for a long receiver hold-off.
  int unsigned          send_idle_pct = 23;
  int unsigned          recv_idle_pct = 23;
  int unsigned          hold_len = 0;
  logic                 hold_go = 1'b0;
  logic                 hold_seen = 1'b0;
  int unsigned          hold_left = 0;

  kary_tree_child_ranks_core DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),     // sender [15:0]
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),     // receiver [15:0], child_index [20:16], zero [23:21]
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Work out the children of one sender under the current configuration and queue them.
  function automatic void predict_children(input logic [15:0] sender);
    longint unsigned k, n, s, base, stride, rem, rank;
    int unsigned     c, kept;
    child_t          child;
    k = 64'(tree_arity);
    n = 64'(tree_nodes);
    s = 64'(sender);
    if (k > MAX_ARITY) k = MAX_ARITY;
    if (k == 0 || s >= n) return;
    if (tree_order == ORDER_HEAP) begin
      base = k * s;
      stride = 1;
    end else begin
      // Strip level sizes 1, k, k^2, ... until the rank falls inside a level.
      base = s;
      stride = 1;
      if (k > 1) begin
        rem = s;
        while (rem >= stride) begin
          rem -= stride;
          stride *= k;
        end
      end
    end
    // Children grow with c, so the kept ones form a prefix.
    kept = 0;
    for (c = 1; c <= k; c++) begin
      if (base + c * stride >= n) break;
      kept++;
    end
    for (c = 1; c <= kept; c++) begin
      rank = base + c * stride;
      child.rank = rank[RANK_W-1:0];
      child.index = c[CHILD_W-1:0];
      child.last = (c == kept);
      child_q.push_back(child);
    end
  endfunction

  // Sender side: present queued items at the falling edge, with random gaps.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || sender_taken) begin
      if (sender_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata <= sender_q.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver side: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= hold_len;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Sample both handshakes at the rising edge; predict on input, check on output.
  always @(posedge clk) begin
    child_t want;
    sender_taken <= !rst && s_tvalid && s_tready;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_children(s_tdata);
        senders_taken++;
      end
      if (m_tvalid && m_tready) begin
        if (child_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected child: rank %0d index %0d last %0b",
                     m_tdata[15:0], m_tdata[20:16], m_tlast);
        end else begin
          want = child_q.pop_front();
          if (m_tdata[15:0] !== want.rank || m_tdata[20:16] !== want.index ||
              m_tlast !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"child mismatch: expected rank %0d index %0d last %0b,",
                        " got rank %0d index %0d last %0b"},
                       want.rank, want.index, want.last,
                       m_tdata[15:0], m_tdata[20:16], m_tlast);
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("kary_tree_child_ranks_core verification failed");
      $finish;
    end
  end

  task automatic offer_sender(input logic [15:0] sender);
    sender_q.push_back(sender);
    senders_queued++;
  endtask

  // Write one register while the block is idle and track it in the mirror.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RANK_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ARITY) tree_arity = value[ARITY_W-1:0];
    else if (idx == REG_NODE_COUNT) tree_nodes = value;
    else if (idx == REG_ORDER_MODE) tree_order = value[0];
  endtask

  task automatic set_tree(input int unsigned k, input int unsigned n, input logic order);
    write_reg(REG_ARITY, k[RANK_W-1:0]);
    write_reg(REG_NODE_COUNT, n[RANK_W-1:0]);
    write_reg(REG_ORDER_MODE, {{(RANK_W-1){1'b0}}, order});
  endtask

  // Wait until every item is taken and every child has come out, then let a
  // childless item still in the search loop finish.
  task automatic settle();
    while (!(senders_taken == senders_queued && child_q.size() == 0))
      @(negedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  // A random tree, then a batch of senders mostly inside it.
  task automatic random_phase(input int unsigned count);
    int unsigned k, n, i;
    logic        order;
    k = ($urandom_range(99) < 85) ? $urandom_range(16, 1) : $urandom_range(31, 0);
    n = ($urandom_range(3) == 0) ? $urandom_range(65535, 0) : $urandom_range(300, 1);
    order = 1'($urandom_range(1));
    set_tree(k, n, order);
    for (i = 0; i < count; i++) begin
      if (n > 0 && $urandom_range(99) < 80)
        offer_sender(16'($urandom_range(n - 1, 0)));
      else
        offer_sender(16'($urandom_range(65535, 0)));
    end
    settle();
  endtask

  initial begin
    int unsigned i;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset configuration: binary interleaved tree of 16 nodes, root, leaves,
    // and senders outside the tree.
    offer_sender(16'd0);
    offer_sender(16'd1);
    offer_sender(16'd7);
    offer_sender(16'd15);
    offer_sender(16'd16);
    offer_sender(16'hFFFF);
    settle();

    // Arity one in interleaved order: the stride is one for every rank.
    set_tree(1, 65535, ORDER_INTERLEAVED);
    offer_sender(16'd0);
    offer_sender(16'd65533);
    offer_sender(16'd65534);
    offer_sender(16'hFFFF);
    settle();

    // Widest arity in heap order, near the top of the rank range.
    set_tree(16, 65535, ORDER_HEAP);
    offer_sender(16'd0);
    offer_sender(16'd4095);
    offer_sender(16'd4096);
    settle();

    // Arity above the maximum saturates, deep interleaved levels.
    set_tree(31, 1000, ORDER_INTERLEAVED);
    offer_sender(16'd0);
    offer_sender(16'd17);
    offer_sender(16'd500);
    settle();

    // Arity zero gives no children.
    write_reg(REG_ARITY, 16'd0);
    offer_sender(16'd0);
    settle();

    // Empty tree, and a one-node tree whose root has no children.
    set_tree(3, 0, ORDER_HEAP);
    offer_sender(16'd0);
    settle();
    write_reg(REG_NODE_COUNT, 16'd1);
    offer_sender(16'd0);
    settle();

    // Random trees.
    random_phase(20);
    random_phase(20);

    // A stretch with no idling on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(20);
    send_idle_pct = 23;
    recv_idle_pct = 23;

    // Hold the receiver off while wide trees keep the sender busy, so the
    // block backs up and stalls its input.
    set_tree(16, 65535, ORDER_INTERLEAVED);
    @(posedge clk);
    hold_len = 400;
    hold_go = ~hold_go;
    for (i = 0; i < 20; i++) offer_sender(16'($urandom_range(4000, 0)));
    settle();

    random_phase(20);

    if (mismatch_count == 0)
      $display("kary_tree_child_ranks_core verification clean");
    else
      $display("kary_tree_child_ranks_core verification failed");
    $finish;
  end

endmodule

@@ kary_tree_child_ranks_core.f @@
design/ktcr_pkg.sv
design/ktcr_ctrl.sv
design/ktcr_dp.sv
design/kary_tree_child_ranks_core.sv
test/kary_tree_child_ranks_core_test.sv
